FILE: rtl/core/psc_pkg.sv
package psc_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_IDX_W = 4;

	typedef enum logic [2:0] {
		PH_OFF          = 3'd0,
		PH_SETTLE       = 3'd1,
		PH_AWAIT_HOMING = 3'd2,
		PH_AWAIT_IDLE   = 3'd3,
		PH_TRAVEL       = 3'd4,
		PH_FAILED       = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ST_UNCHANGED       = 4'd0,
		ST_NOT_CONNECTED   = 4'd1,
		ST_BUSY            = 4'd2,
		ST_UNLOCKING       = 4'd3,
		ST_LIFTING         = 4'd4,
		ST_HOMING          = 4'd5,
		ST_NO_SETTLE       = 4'd6,
		ST_HOMING_NO_START = 4'd7,
		ST_HOMING_FAILED   = 4'd8,
		ST_PARKING         = 4'd9,
		ST_HOMING_TIMEOUT  = 4'd10,
		ST_PARKED          = 4'd11
	} status_t;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_RUN    = 3'd1;
	localparam logic [2:0] MODE_HOLD   = 3'd2;
	localparam logic [2:0] MODE_ALARM  = 3'd3;
	localparam logic [2:0] MODE_HOMING = 3'd4;
	localparam logic [2:0] MODE_DONE   = 3'd5;

	localparam logic KIND_TRIGGER = 1'b0;
	localparam logic KIND_UPDATE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SETTLE         = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIMEOUT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_START_TO  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_DONE_TO   = 4'd3;

	localparam logic [TIME_W-1:0] SETTLE_MS_RST          = 32'd500;
	localparam logic [TIME_W-1:0] SETTLE_TIMEOUT_MS_RST  = 32'd8000;
	localparam logic [TIME_W-1:0] HOME_START_TIMEOUT_RST = 32'd10000;
	localparam logic [TIME_W-1:0] HOME_DONE_TIMEOUT_RST  = 32'd180000;

endpackage

FILE: rtl/core/park_sequence_controller.sv
// Pen-lift, home and park sequencer.
// Input channel (in_valid/in_ready): one transaction per trigger (kind 0) or
// update tick (kind 1), with the current millisecond time and machine flags.
// Output channel (out_valid/out_ready): exactly one result transaction per
// input transaction, in order: phase after the item, status code and the
// lift, home and park pulses.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; indexes 0..3
// select settle, settle timeout, homing start timeout and homing done timeout.
// Other indexes are dropped. Write only while the block is empty.
// An accepted item waits in the input register; its result then loads the
// result register, one item per cycle unless the receiver stalls. Phase and
// phase start update as the result register loads, so the next item sees them.
// Reset: phase off, phase start 0, timing registers to their defaults,
// both pipeline registers empty.
// Receiver stall: the result register holds, the input register holds, and
// in_ready falls once both are full.
module park_sequence_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [31:0]                     now_ms,
	input  logic                            link_up,
	input  logic                            job_running,
	input  logic [2:0]                      machine_mode,
	input  logic                            pen_lowered,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      phase_now,
	output logic [3:0]                      status_code,
	output logic                            lift_pulse,
	output logic                            home_pulse,
	output logic                            park_pulse,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	logic [psc_pkg::TIME_W-1:0] settle_ms_q;
	logic [psc_pkg::TIME_W-1:0] settle_to_q;
	logic [psc_pkg::TIME_W-1:0] home_start_to_q;
	logic [psc_pkg::TIME_W-1:0] home_done_to_q;

	psc_pkg::phase_t            phase_q;
	logic [psc_pkg::TIME_W-1:0] phase_start_q;

	logic                       valid_s1;
	logic                       kind_s1;
	logic [psc_pkg::TIME_W-1:0] now_s1;
	logic                       link_s1;
	logic                       job_s1;
	logic [2:0]                 mode_s1;
	logic                       pen_s1;

	logic                       out_valid_q;
	psc_pkg::phase_t            phase_out_q;
	psc_pkg::status_t           status_out_q;
	logic                       lift_q;
	logic                       home_q;
	logic                       park_q;

	logic                       advance;
	logic                       accept_in;
	logic [psc_pkg::TIME_W-1:0] elapsed;
	logic                       do_enter;
	psc_pkg::phase_t            phase_nxt;
	psc_pkg::status_t           status_nxt;
	logic                       lift_nxt;
	logic                       home_nxt;
	logic                       park_nxt;
	logic                       quiet;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign accept_in = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q     <= psc_pkg::SETTLE_MS_RST;
			settle_to_q     <= psc_pkg::SETTLE_TIMEOUT_MS_RST;
			home_start_to_q <= psc_pkg::HOME_START_TIMEOUT_RST;
			home_done_to_q  <= psc_pkg::HOME_DONE_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psc_pkg::REG_SETTLE:         settle_ms_q     <= cfg_data;
				psc_pkg::REG_SETTLE_TIMEOUT: settle_to_q     <= cfg_data;
				psc_pkg::REG_HOME_START_TO:  home_start_to_q <= cfg_data;
				psc_pkg::REG_HOME_DONE_TO:   home_done_to_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_s1 <= kind;
			now_s1  <= now_ms;
			link_s1 <= link_up;
			job_s1  <= job_running;
			mode_s1 <= machine_mode;
			pen_s1  <= pen_lowered;
		end
	end

	assign elapsed = now_s1 - phase_start_q;
	assign quiet   = (mode_s1 == psc_pkg::MODE_IDLE) || (mode_s1 == psc_pkg::MODE_ALARM);

	always_comb begin
		phase_nxt  = phase_q;
		status_nxt = psc_pkg::ST_UNCHANGED;
		do_enter   = 1'b0;
		lift_nxt   = 1'b0;
		home_nxt   = 1'b0;
		park_nxt   = 1'b0;
		if (kind_s1 == psc_pkg::KIND_TRIGGER) begin
			if (phase_q inside {psc_pkg::PH_OFF, psc_pkg::PH_FAILED}) begin
				do_enter = 1'b1;
				if (!link_s1) begin
					phase_nxt  = psc_pkg::PH_FAILED;
					status_nxt = psc_pkg::ST_NOT_CONNECTED;
				end else if (job_s1 || mode_s1 inside {psc_pkg::MODE_RUN, psc_pkg::MODE_HOLD}) begin
					phase_nxt  = psc_pkg::PH_FAILED;
					status_nxt = psc_pkg::ST_BUSY;
				end else if (mode_s1 == psc_pkg::MODE_ALARM) begin
					phase_nxt  = psc_pkg::PH_SETTLE;
					status_nxt = psc_pkg::ST_UNLOCKING;
				end else begin
					phase_nxt  = psc_pkg::PH_SETTLE;
					status_nxt = psc_pkg::ST_LIFTING;
					lift_nxt   = pen_s1;
				end
			end
		end else begin
			case (phase_q)
				psc_pkg::PH_SETTLE: begin
					if (elapsed >= settle_ms_q && quiet) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_AWAIT_HOMING;
						status_nxt = psc_pkg::ST_HOMING;
						home_nxt   = 1'b1;
					end else if (elapsed >= settle_to_q) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_FAILED;
						status_nxt = psc_pkg::ST_NO_SETTLE;
					end
				end
				psc_pkg::PH_AWAIT_HOMING: begin
					if (mode_s1 == psc_pkg::MODE_HOMING) begin
						do_enter  = 1'b1;
						phase_nxt = psc_pkg::PH_AWAIT_IDLE;
					end else if (elapsed >= home_start_to_q) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_FAILED;
						status_nxt = psc_pkg::ST_HOMING_NO_START;
					end
				end
				psc_pkg::PH_AWAIT_IDLE: begin
					if (mode_s1 == psc_pkg::MODE_ALARM) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_FAILED;
						status_nxt = psc_pkg::ST_HOMING_FAILED;
					end else if (mode_s1 inside {psc_pkg::MODE_IDLE, psc_pkg::MODE_DONE}) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_TRAVEL;
						status_nxt = psc_pkg::ST_PARKING;
						park_nxt   = 1'b1;
					end else if (elapsed >= home_done_to_q) begin
						do_enter   = 1'b1;
						phase_nxt  = psc_pkg::PH_FAILED;
						status_nxt = psc_pkg::ST_HOMING_TIMEOUT;
					end
				end
				psc_pkg::PH_TRAVEL: begin
					do_enter   = 1'b1;
					phase_nxt  = psc_pkg::PH_OFF;
					status_nxt = psc_pkg::ST_PARKED;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= psc_pkg::PH_OFF;
			phase_start_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			if (do_enter) begin
				phase_start_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_out_q  <= phase_nxt;
			status_out_q <= status_nxt;
			lift_q       <= lift_nxt;
			home_q       <= home_nxt;
			park_q       <= park_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign phase_now   = phase_out_q;
	assign status_code = status_out_q;
	assign lift_pulse  = lift_q;
	assign home_pulse  = home_q;
	assign park_pulse  = park_q;

endmodule

FILE: rtl/core/psc_checker.sv
module psc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] phase_now,
	input logic [3:0] status_code,
	input logic       lift_pulse,
	input logic       home_pulse,
	input logic       park_pulse
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase_now) && $stable(status_code))
		else $error("result changed while stalled");

	a_lift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lift_pulse |-> status_code == psc_pkg::ST_LIFTING
			&& phase_now == psc_pkg::PH_SETTLE)
		else $error("lift pulse outside a lifting start");

	a_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && home_pulse |-> status_code == psc_pkg::ST_HOMING
			&& phase_now == psc_pkg::PH_AWAIT_HOMING && !lift_pulse && !park_pulse)
		else $error("home pulse inconsistent with status");

	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && park_pulse |-> status_code == psc_pkg::ST_PARKING
			&& phase_now == psc_pkg::PH_TRAVEL && !lift_pulse)
		else $error("park pulse inconsistent with status");

	a_parked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_code == psc_pkg::ST_PARKED |-> phase_now == psc_pkg::PH_OFF)
		else $error("parked status without return to off");

endmodule

bind park_sequence_controller psc_checker u_psc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.phase_now   (phase_now),
	.status_code (status_code),
	.lift_pulse  (lift_pulse),
	.home_pulse  (home_pulse),
	.park_pulse  (park_pulse)
);
